// ===== rtl/hsvrgb_pkg.sv =====
// Shared constants, fixed-point formats and transaction structs for the
// HSV to RGB converter pipeline. No dependencies.
package hsvrgb_pkg;

    // Field formats
    localparam int HUE_FRAC_BITS  = 6;
    localparam int UNIT_FRAC_BITS = 12;
    localparam int HUE_W          = 16;
    localparam int SAT_W          = 13;
    localparam int BRIGHT_W       = 13;
    localparam int CHAN_W         = 8;
    localparam int CHAN_MAX       = 255;

    // One sector is 60 degrees; 60 = 15 * 4, so hue / D = (hue >> (HFB + 2)) / 15
    localparam int SECTOR_WIDTH = 60 << HUE_FRAC_BITS;
    localparam int SECTOR_MAX   = ((2 ** HUE_W) - 1) / SECTOR_WIDTH;
    localparam int SECT_W       = $clog2(SECTOR_MAX + 1);
    localparam int REM_W        = $clog2(SECTOR_WIDTH);
    localparam int K_W          = $clog2(SECTOR_WIDTH + 1);
    localparam int BASE_W       = HUE_W + 1;

    // Reciprocal of 15 for the sector quotient
    localparam int HX_W         = HUE_W - HUE_FRAC_BITS - 2;
    localparam int RECIP_SHIFT  = 20;
    localparam int RECIP_W      = RECIP_SHIFT - 3;
    localparam int RECIP        = ((2 ** RECIP_SHIFT) / 15) + 1;
    localparam int QPROD_W      = HX_W + RECIP_W;

    // Channel arithmetic: 255 * v * (D*U - k*s) / (D*U*U)
    //   = 17 * v * (D*U - k*s) >> (HFB + 2*UFB + 2)
    localparam longint FULL     = longint'(SECTOR_WIDTH) << UNIT_FRAC_BITS;
    localparam int SUB_W        = K_W + SAT_W;
    localparam int DIFF_W       = $clog2(FULL + 1);
    localparam int CMP_W        = (SUB_W > DIFF_W) ? SUB_W : DIFF_W;
    localparam int V17_W        = BRIGHT_W + 5;
    localparam int PROD_W       = V17_W + DIFF_W;
    localparam int SCALE_SHIFT  = HUE_FRAC_BITS + 2 * UNIT_FRAC_BITS + 2;
    localparam int SCALED_W     = (PROD_W - SCALE_SHIFT > CHAN_W) ?
                                  (PROD_W - SCALE_SHIFT) : (CHAN_W + 1);

    // Hue sectors
    localparam logic [SECT_W-1:0] SEC_RED_YEL = SECT_W'(0);
    localparam logic [SECT_W-1:0] SEC_YEL_GRN = SECT_W'(1);
    localparam logic [SECT_W-1:0] SEC_GRN_CYN = SECT_W'(2);
    localparam logic [SECT_W-1:0] SEC_CYN_BLU = SECT_W'(3);
    localparam logic [SECT_W-1:0] SEC_BLU_MAG = SECT_W'(4);
    localparam logic [SECT_W-1:0] SEC_MAG_RED = SECT_W'(5);

    // Sector front end to channel arithmetic
    typedef struct packed {
        logic [SECT_W-1:0]   sector;
        logic [REM_W-1:0]    rem;
        logic [K_W-1:0]      tk;
        logic [SAT_W-1:0]    sat;
        logic [BRIGHT_W-1:0] bright;
    } hsvrgb_pos_t;

    // Channel arithmetic to sector mapping
    typedef struct packed {
        logic [SECT_W-1:0]   sector;
        logic [SCALED_W-1:0] cv;
        logic [SCALED_W-1:0] cp;
        logic [SCALED_W-1:0] cq;
        logic [SCALED_W-1:0] ct;
    } hsvrgb_chan_t;

endpackage

// ===== rtl/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: six-stage pipeline built from
// hsvrgb_sector, hsvrgb_chan and hsvrgb_map. Depends on hsvrgb_pkg.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------
//   HSV in  | hsv_valid / hsv_ready | hue[15:0], saturation[12:0], brightness[12:0]
//   RGB out | rgb_valid / rgb_ready | red[7:0], green[7:0], blue[7:0]
//
// One transaction per clock sustained while rgb_ready stays high. The accepting
// edge loads the first of six register stages: two sector stages, three channel
// multiply stages and the output register. rgb_valid rises once the transaction
// reaches the output register. Reset clears the stage valid bits only. Each stage
// holds only while it is full and the stage after it cannot take data, so
// empty slots close up under a stall and hsv_ready stays high until the
// whole pipe is full.
module hsv_to_rgb_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            hsv_valid,
    output logic                            hsv_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]    hue,
    input  logic [hsvrgb_pkg::SAT_W-1:0]    saturation,
    input  logic [hsvrgb_pkg::BRIGHT_W-1:0] brightness,
    output logic                            rgb_valid,
    input  logic                            rgb_ready,
    output logic [hsvrgb_pkg::CHAN_W-1:0]   red,
    output logic [hsvrgb_pkg::CHAN_W-1:0]   green,
    output logic [hsvrgb_pkg::CHAN_W-1:0]   blue
);
    import hsvrgb_pkg::*;

    logic         pos_valid;
    logic         pos_ready;
    hsvrgb_pos_t  pos;
    logic         chan_valid;
    logic         chan_ready;
    hsvrgb_chan_t chan;

    hsvrgb_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hsv_valid),
        .in_ready   (hsv_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (pos_valid),
        .out_ready  (pos_ready),
        .out_pos    (pos)
    );

    hsvrgb_chan u_chan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pos_valid),
        .in_ready  (pos_ready),
        .in_pos    (pos),
        .out_valid (chan_valid),
        .out_ready (chan_ready),
        .out_chan  (chan)
    );

    hsvrgb_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chan_valid),
        .in_ready  (chan_ready),
        .in_chan   (chan),
        .out_valid (rgb_valid),
        .out_ready (rgb_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

// ===== rtl/hsvrgb_sector.sv =====
// Two pipeline stages: hue sector by reciprocal multiply, then the remainder
// within the sector and its complement. Depends on hsvrgb_pkg.
module hsvrgb_sector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]    hue,
    input  logic [hsvrgb_pkg::SAT_W-1:0]    saturation,
    input  logic [hsvrgb_pkg::BRIGHT_W-1:0] brightness,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hsvrgb_pkg::hsvrgb_pos_t       out_pos
);
    import hsvrgb_pkg::*;

    logic                a_valid_reg;
    logic                a_ready;
    logic [HUE_W-1:0]    a_hue_reg;
    logic [SAT_W-1:0]    a_sat_reg;
    logic [BRIGHT_W-1:0] a_bright_reg;
    logic [SECT_W-1:0]   a_sector_reg;
    logic [SECT_W-1:0]   a_sector_next;
    logic [HX_W-1:0]     hx;
    logic [QPROD_W-1:0]  qprod;

    logic                b_valid_reg;
    logic                b_ready;
    hsvrgb_pos_t         b_pos_reg;
    hsvrgb_pos_t         b_pos_next;
    logic [BASE_W-1:0]   base;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    // floor(hue / D) = floor((hue >> (HFB + 2)) / 15)
    assign hx            = hue[HUE_W-1:HUE_W-HX_W];
    assign qprod         = QPROD_W'(hx) * QPROD_W'(RECIP);
    assign a_sector_next = SECT_W'(qprod >> RECIP_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_hue_reg    <= hue;
            a_sat_reg    <= saturation;
            a_bright_reg <= brightness;
            a_sector_reg <= a_sector_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_pos_reg <= b_pos_next;
        end
    end

    always_comb
    begin
        base              = BASE_W'(a_sector_reg) * BASE_W'(SECTOR_WIDTH);
        b_pos_next.sector = a_sector_reg;
        b_pos_next.rem    = REM_W'(BASE_W'(a_hue_reg) - base);
        b_pos_next.tk     = K_W'(base + BASE_W'(SECTOR_WIDTH) - BASE_W'(a_hue_reg));
        b_pos_next.sat    = a_sat_reg;
        b_pos_next.bright = a_bright_reg;
    end

    assign out_valid = b_valid_reg;
    assign out_pos   = b_pos_reg;

endmodule

// ===== rtl/hsvrgb_chan.sv =====
// Three pipeline stages of channel arithmetic: k*s products, clamped
// differences from full scale, then the brightness product. Depends on hsvrgb_pkg.
module hsvrgb_chan (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  hsvrgb_pkg::hsvrgb_pos_t in_pos,
    output logic                    out_valid,
    input  logic                    out_ready,
    output hsvrgb_pkg::hsvrgb_chan_t out_chan
);
    import hsvrgb_pkg::*;

    // stage C: saturation products
    logic                c_valid_reg;
    logic                c_ready;
    logic [SECT_W-1:0]   c_sector_reg;
    logic [BRIGHT_W-1:0] c_bright_reg;
    logic [SUB_W-1:0]    c_subp_reg;
    logic [SUB_W-1:0]    c_subq_reg;
    logic [SUB_W-1:0]    c_subt_reg;

    // stage D: differences and 17*v
    logic                d_valid_reg;
    logic                d_ready;
    logic [SECT_W-1:0]   d_sector_reg;
    logic [V17_W-1:0]    d_v17_reg;
    logic [DIFF_W-1:0]   d_diffp_reg;
    logic [DIFF_W-1:0]   d_diffq_reg;
    logic [DIFF_W-1:0]   d_difft_reg;

    // stage E: scaled channels
    logic                e_valid_reg;
    logic                e_ready;
    hsvrgb_chan_t        e_chan_reg;
    hsvrgb_chan_t        e_chan_next;

    function automatic logic [DIFF_W-1:0] sub_from_full(input logic [SUB_W-1:0] sub);
        logic [DIFF_W-1:0] res;
        if (CMP_W'(sub) >= CMP_W'(FULL))
        begin
            res = '0;
        end
        else
        begin
            res = DIFF_W'(CMP_W'(FULL) - CMP_W'(sub));
        end
        return res;
    endfunction

    function automatic logic [SCALED_W-1:0] scale(input logic [V17_W-1:0] v17,
                                                  input logic [DIFF_W-1:0] diff);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(v17) * PROD_W'(diff);
        return SCALED_W'(prod >> SCALE_SHIFT);
    endfunction

    assign c_ready  = !c_valid_reg || d_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign e_ready  = !e_valid_reg || out_ready;
    assign in_ready = c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_sector_reg <= in_pos.sector;
            c_bright_reg <= in_pos.bright;
            c_subp_reg   <= SUB_W'(SECTOR_WIDTH) * SUB_W'(in_pos.sat);
            c_subq_reg   <= SUB_W'(in_pos.rem) * SUB_W'(in_pos.sat);
            c_subt_reg   <= SUB_W'(in_pos.tk) * SUB_W'(in_pos.sat);
        end
        if (d_ready && c_valid_reg)
        begin
            d_sector_reg <= c_sector_reg;
            d_v17_reg    <= (V17_W'(c_bright_reg) << 4) + V17_W'(c_bright_reg);
            d_diffp_reg  <= sub_from_full(c_subp_reg);
            d_diffq_reg  <= sub_from_full(c_subq_reg);
            d_difft_reg  <= sub_from_full(c_subt_reg);
        end
        if (e_ready && d_valid_reg)
        begin
            e_chan_reg <= e_chan_next;
        end
    end

    always_comb
    begin
        e_chan_next.sector = d_sector_reg;
        e_chan_next.cv     = scale(d_v17_reg, DIFF_W'(FULL));
        e_chan_next.cp     = scale(d_v17_reg, d_diffp_reg);
        e_chan_next.cq     = scale(d_v17_reg, d_diffq_reg);
        e_chan_next.ct     = scale(d_v17_reg, d_difft_reg);
    end

    assign out_valid = e_valid_reg;
    assign out_chan  = e_chan_reg;

endmodule

// ===== rtl/hsvrgb_map.sv =====
// Output stage: saturate each channel to 8 bits and route V, p, q, t to
// red, green and blue by hue sector. Depends on hsvrgb_pkg.
module hsvrgb_map (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hsvrgb_pkg::hsvrgb_chan_t      in_chan,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hsvrgb_pkg::CHAN_W-1:0] red,
    output logic [hsvrgb_pkg::CHAN_W-1:0] green,
    output logic [hsvrgb_pkg::CHAN_W-1:0] blue
);
    import hsvrgb_pkg::*;

    logic              f_valid_reg;
    logic              f_ready;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] sv;
    logic [CHAN_W-1:0] sp;
    logic [CHAN_W-1:0] sq;
    logic [CHAN_W-1:0] st;

    function automatic logic [CHAN_W-1:0] clamp(input logic [SCALED_W-1:0] x);
        logic [CHAN_W-1:0] res;
        if (x > SCALED_W'(CHAN_MAX))
        begin
            res = CHAN_W'(CHAN_MAX);
        end
        else
        begin
            res = x[CHAN_W-1:0];
        end
        return res;
    endfunction

    assign f_ready  = !f_valid_reg || out_ready;
    assign in_ready = f_ready;

    always_comb
    begin
        sv = clamp(in_chan.cv);
        sp = clamp(in_chan.cp);
        sq = clamp(in_chan.cq);
        st = clamp(in_chan.ct);
        unique case (in_chan.sector)
            SEC_RED_YEL:
            begin
                red_next = sv; green_next = st; blue_next = sp;
            end
            SEC_YEL_GRN:
            begin
                red_next = sq; green_next = sv; blue_next = sp;
            end
            SEC_GRN_CYN:
            begin
                red_next = sp; green_next = sv; blue_next = st;
            end
            SEC_CYN_BLU:
            begin
                red_next = sp; green_next = sq; blue_next = sv;
            end
            SEC_BLU_MAG:
            begin
                red_next = st; green_next = sp; blue_next = sv;
            end
            SEC_MAG_RED:
            begin
                red_next = sv; green_next = sp; blue_next = sq;
            end
            default:
            begin
                // hue at or past 360 degrees: black
                red_next = '0; green_next = '0; blue_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (f_ready)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_ready && in_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule
